// File: rtl/bsas_pkg.sv
// shared types and constants for the block signal aspect sequencer
`timescale 1ns / 1ps

package bsas_pkg;

    // aspect codes
    localparam logic [1:0] ASPECT_GO   = 2'd0;
    localparam logic [1:0] ASPECT_SLOW = 2'd1;
    localparam logic [1:0] ASPECT_WARN = 2'd2;
    localparam logic [1:0] ASPECT_STOP = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DETECT_FRAMES     = 2'd0;
    localparam logic [1:0] CFG_TRANSITION_FRAMES = 2'd1;

    localparam logic [7:0] DETECT_FRAMES_RST     = 8'd3;
    localparam logic [7:0] TRANSITION_FRAMES_RST = 8'd10;

    localparam int SAMPLE_W = 10;
    localparam int COUNT_W  = 9;

    typedef struct packed {
        logic [1:0]         aspect;
        logic [COUNT_W-1:0] debounce_count;
        logic [COUNT_W-1:0] transition_count;
    } seq_state_t;

    typedef struct packed {
        logic       train_flag;
        logic       above_threshold;
        logic       lamp_green;
        logic       lamp_yellow_lower;
        logic       lamp_red;
        logic       lamp_yellow_upper;
        logic [1:0] aspect;
    } seq_result_t;

endpackage

// File: rtl/bsas_step.sv
// per-tick debounce, aspect update and lamp decode
`timescale 1ns / 1ps

module bsas_step import bsas_pkg::*; (
    input  logic [SAMPLE_W-1:0] sensor_sample,
    input  logic [SAMPLE_W-1:0] threshold_sample,
    input  logic [7:0]          detect_frames,
    input  logic [7:0]          transition_frames,
    input  seq_state_t          state_cur,
    output seq_state_t          state_new,
    output seq_result_t         result
);

    logic               above;
    logic               flag;
    logic [COUNT_W-1:0] deb_inc;
    logic [COUNT_W-1:0] deb_reload;
    logic [COUNT_W-1:0] trn_inc;
    logic               trn_fire;
    logic [1:0]         aspect_new;

    assign above   = sensor_sample > threshold_sample;
    // counters never exceed 256, so the increment cannot wrap
    assign deb_inc = state_cur.debounce_count + COUNT_W'(1);
    assign flag    = above && (deb_inc > {1'b0, detect_frames});
    // reload saturates at zero for a detect count of zero
    assign deb_reload = (detect_frames == 8'd0) ? '0 : {1'b0, detect_frames - 8'd1};

    assign trn_inc  = state_cur.transition_count + COUNT_W'(1);
    assign trn_fire = trn_inc > {1'b0, transition_frames};

    always_comb begin
        state_new = state_cur;
        if (!above) begin
            state_new.debounce_count = '0;
        end else if (flag) begin
            state_new.debounce_count = deb_reload;
        end else begin
            state_new.debounce_count = deb_inc;
        end

        aspect_new = state_cur.aspect;
        if (flag) begin
            if (state_cur.aspect == ASPECT_STOP) begin
                state_new.transition_count = '0;
            end
            aspect_new = ASPECT_STOP;
        end else if (state_cur.aspect != ASPECT_GO) begin
            if (trn_fire) begin
                state_new.transition_count = '0;
                aspect_new = state_cur.aspect - 2'd1;
            end else begin
                state_new.transition_count = trn_inc;
            end
        end
        state_new.aspect = aspect_new;
    end

    assign result.aspect            = aspect_new;
    assign result.lamp_yellow_upper = (aspect_new == ASPECT_SLOW);
    assign result.lamp_red          = (aspect_new == ASPECT_STOP);
    assign result.lamp_yellow_lower = (aspect_new == ASPECT_WARN);
    assign result.lamp_green        = (aspect_new == ASPECT_GO) || (aspect_new == ASPECT_SLOW);
    assign result.above_threshold   = above;
    assign result.train_flag        = flag;

endmodule

// File: rtl/block_signal_aspect_sequencer.sv
// top level of the block signal aspect sequencer
`timescale 1ns / 1ps

// one transaction on the slave side is one timer tick: a sensor sample and a
// threshold sample. each tick yields exactly one master-side transaction with
// the aspect after the tick, the four lamp bits, the raw comparison and the
// debounced train flag
// pipeline: an input register, then the tick logic, then the result register;
// a result is offered on the master side once its tick enters the result register
// throughput is one tick per cycle while the receiver does not stall; the state
// registers update as a tick moves from the input register into the result register
// when the receiver stalls, the result register holds its transaction and the
// input register still takes one more tick; after that s_tready drops
// configuration is a plain write port: index 0 detect_frames, index 1
// transition_frames; other indexes are ignored. write only while idle
// reset (aresetn low, synchronous) empties both stages, puts the aspect in
// go, clears both counters and loads detect_frames 3, transition_frames 10

module block_signal_aspect_sequencer import bsas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [9:0] sensor_sample, [19:10] threshold_sample, rest zero
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [1:0] aspect, [2] lamp_yellow_upper, [3] lamp_red,
                                     // [4] lamp_yellow_lower, [5] lamp_green,
                                     // [6] above_threshold, [7] train_flag
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);

    // configuration registers
    logic [7:0] detect_frames_reg;
    logic [7:0] transition_frames_reg;

    // input stage
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sensor_reg;
    logic [SAMPLE_W-1:0] threshold_reg;

    // sequencer state
    seq_state_t  state_reg;
    seq_state_t  state_next;

    // result stage
    logic        out_valid_reg;
    seq_result_t result_reg;
    seq_result_t result_next;

    logic        advance;
    logic        s_accept;

    // the input stage moves on when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_frames_reg     <= DETECT_FRAMES_RST;
            transition_frames_reg <= TRANSITION_FRAMES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DETECT_FRAMES:     detect_frames_reg     <= cfg_wr_data;
                CFG_TRANSITION_FRAMES: transition_frames_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sensor_reg    <= s_tdata[SAMPLE_W-1:0];
            threshold_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    bsas_step u_step (
        .sensor_sample     (sensor_reg),
        .threshold_sample  (threshold_reg),
        .detect_frames     (detect_frames_reg),
        .transition_frames (transition_frames_reg),
        .state_cur         (state_reg),
        .state_new         (state_next),
        .result            (result_next)
    );

    // state commits once per tick as it enters the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.aspect           <= ASPECT_GO;
            state_reg.debounce_count   <= '0;
            state_reg.transition_count <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

// File: dv/testbench.sv
// self-checking testbench for the block signal aspect sequencer
`timescale 1ns / 1ps

module testbench;
    import bsas_pkg::*;

    // extra quiet cycles after the last owed result has come out
    localparam int          DRAIN_CYCLES    = 6;
    // watchdog, far above the slowest legal run
    localparam longint      TIMEOUT_NS      = 64'd8_000_000;
    // index that decodes to no register, must be ignored
    localparam logic [1:0]  CFG_SPARE_INDEX = 2'd2;
    localparam int          MAX_PRINTED     = 40;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;   // [9:0] sensor_sample, [19:10] threshold_sample
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;            // [1:0] aspect, [2] yellow upper, [3] red,
                                     // [4] yellow lower, [5] green, [6] above, [7] flag
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [7:0]  cfg_wr_data = '0;

    block_signal_aspect_sequencer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // local copy of the sequencer: registers and state
    logic [7:0]  det_frames;
    logic [7:0]  trans_frames;
    logic [1:0]  cur_aspect;
    logic [8:0]  deb_count;
    logic [8:0]  trn_count;

    // lamp words still owed by the block, oldest first
    seq_result_t expected_lamps[$];

    // idling controls for the sender and the receiver
    bit          src_idle_en   = 1'b1;
    bit          sink_idle_en  = 1'b1;
    int unsigned rx_hold_cycles = 0;

    // bookkeeping
    int unsigned err_count   = 0;
    int unsigned n_ticks     = 0;
    int unsigned n_results   = 0;
    int unsigned n_flags     = 0;
    int unsigned n_in_stalls = 0;
    int unsigned n_settings  = 0;
    int unsigned aspect_seen[4] = '{0, 0, 0, 0};

    task automatic reset_model;
        det_frames   = DETECT_FRAMES_RST;
        trans_frames = TRANSITION_FRAMES_RST;
        cur_aspect   = ASPECT_GO;
        deb_count    = '0;
        trn_count    = '0;
    endtask

    // one tick through the debounce and aspect logic, queues the lamp word
    task automatic predict_aspect(input logic [9:0] sens, input logic [9:0] thr);
        seq_result_t lamps;
        logic        above;
        logic        flag;
        logic [1:0]  a;
        above = sens > thr;
        flag  = 1'b0;
        // debounce runs in every aspect
        if (!above) begin
            deb_count = '0;
        end else begin
            deb_count = deb_count + 9'd1;
            if (deb_count > {1'b0, det_frames}) begin
                // reload saturates at zero when detect_frames is zero
                deb_count = (det_frames == 8'd0) ? 9'd0 : {1'b0, det_frames - 8'd1};
                flag      = 1'b1;
            end
        end
        a = cur_aspect;
        if (flag) begin
            // a repeated detection in stop restarts the relax timer
            if (a == ASPECT_STOP) trn_count = '0;
            a = ASPECT_STOP;
        end else if (a != ASPECT_GO) begin
            trn_count = trn_count + 9'd1;
            if (trn_count > {1'b0, trans_frames}) begin
                trn_count = '0;
                a         = a - 2'd1;
            end
        end
        cur_aspect = a;
        lamps.aspect            = a;
        lamps.lamp_yellow_upper = (a == ASPECT_SLOW);
        lamps.lamp_red          = (a == ASPECT_STOP);
        lamps.lamp_yellow_lower = (a == ASPECT_WARN);
        lamps.lamp_green        = (a == ASPECT_GO) || (a == ASPECT_SLOW);
        lamps.above_threshold   = above;
        lamps.train_flag        = flag;
        expected_lamps.push_back(lamps);
    endtask

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
                     exp_val, got_val);
        err_count++;
    endtask

    task automatic check_lamps(input seq_result_t got);
        seq_result_t exp_w;
        if (expected_lamps.size() == 0) begin
            report_mismatch("unexpected transaction", -1, int'(got));
            return;
        end
        exp_w = expected_lamps.pop_front();
        if (got.aspect !== exp_w.aspect)
            report_mismatch("aspect", int'(exp_w.aspect), int'(got.aspect));
        if (got.lamp_yellow_upper !== exp_w.lamp_yellow_upper)
            report_mismatch("lamp_yellow_upper", int'(exp_w.lamp_yellow_upper),
                            int'(got.lamp_yellow_upper));
        if (got.lamp_red !== exp_w.lamp_red)
            report_mismatch("lamp_red", int'(exp_w.lamp_red), int'(got.lamp_red));
        if (got.lamp_yellow_lower !== exp_w.lamp_yellow_lower)
            report_mismatch("lamp_yellow_lower", int'(exp_w.lamp_yellow_lower),
                            int'(got.lamp_yellow_lower));
        if (got.lamp_green !== exp_w.lamp_green)
            report_mismatch("lamp_green", int'(exp_w.lamp_green), int'(got.lamp_green));
        if (got.above_threshold !== exp_w.above_threshold)
            report_mismatch("above_threshold", int'(exp_w.above_threshold),
                            int'(got.above_threshold));
        if (got.train_flag !== exp_w.train_flag)
            report_mismatch("train_flag", int'(exp_w.train_flag), int'(got.train_flag));
        n_results++;
        if (exp_w.train_flag) n_flags++;
        aspect_seen[exp_w.aspect]++;
    endtask

    // result monitor: a transaction completes at an edge with tvalid and tready high
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_lamps(seq_result_t'(m_tdata));
            if (s_tvalid && !s_tready) n_in_stalls++;
        end
    end

    // receiver: random stalls, plus a long hold-off counted here when asked
    initial begin
        wait (aresetn);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // offer one tick, optionally after an idle burst, and wait for the handshake
    task automatic send_tick(input logic [9:0] sens, input logic [9:0] thr);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, thr, sens};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_aspect(sens, thr);
        n_ticks++;
    endtask

    task automatic send_above;
        logic [9:0] thr;
        logic [9:0] sens;
        thr  = 10'($urandom_range(0, 1022));
        sens = 10'($urandom_range(int'(thr) + 1, 1023));
        send_tick(sens, thr);
    endtask

    task automatic send_below;
        logic [9:0] thr;
        logic [9:0] sens;
        sens = 10'($urandom_range(0, 1023));
        thr  = 10'($urandom_range(int'(sens), 1023));
        send_tick(sens, thr);
    endtask

    task automatic send_noise;
        send_tick(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    endtask

    // stop offering and wait until every owed result has come out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_lamps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only while idle; cfg_wr_en drops again after each
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx == CFG_DETECT_FRAMES)          det_frames   = val;
        else if (idx == CFG_TRANSITION_FRAMES) trans_frames = val;
        n_settings++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // reset values: sample extremes, bit patterns, a detection and a relax to warn
    task automatic test_directed_defaults;
        send_tick(10'd1023, 10'd0);
        send_tick(10'd0, 10'd1023);
        send_tick(10'd512, 10'd512);       // equal is not above
        send_tick(10'd0, 10'd0);
        send_tick(10'd1023, 10'd1023);
        send_tick(10'h2AA, 10'h155);
        send_tick(10'h155, 10'h2AA);
        repeat (4) send_above;             // fourth one flags, go to stop
        send_above;                        // reloaded counter, no flag yet
        send_above;                        // flag again while in stop
        repeat (12) send_below;            // relax timer passes 10, stop to warn
    endtask

    // zero detect frames and zero transition frames, then writes to unused indexes
    task automatic test_zero_frames;
        drain;
        write_reg(CFG_DETECT_FRAMES, 8'd0);
        write_reg(CFG_TRANSITION_FRAMES, 8'd0);
        send_above;                        // every above tick flags
        repeat (3) send_below;             // every tick relaxes one step
        send_above;
        send_above;
        repeat (4) send_below;
        drain;
        write_reg(CFG_SPARE_INDEX, 8'hFF); // ignored by the block
        write_reg(CFG_SPARE_INDEX + 2'd1, 8'hA5);
        repeat (6) send_noise;
    endtask

    // both counters run up to 256: start in warn so the relax timer keeps
    // counting through the detection and fires on the tick after it
    task automatic test_counter_bounds;
        drain;
        write_reg(CFG_DETECT_FRAMES, 8'd0);
        write_reg(CFG_TRANSITION_FRAMES, 8'd0);
        send_above;                        // go to stop
        send_below;                        // stop to warn
        drain;
        write_reg(CFG_DETECT_FRAMES, 8'd255);
        write_reg(CFG_TRANSITION_FRAMES, 8'd255);
        repeat (258) send_above;
        repeat (4) send_below;
    endtask

    // train-like runs of above and below ticks with random content, some noise
    task automatic test_random_sequences;
        int unsigned phase_start;
        int unsigned run;
        for (int p = 0; p < 2; p++) begin
            drain;
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_DETECT_FRAMES, 8'($urandom_range(0, 255)));
            else
                write_reg(CFG_DETECT_FRAMES, 8'($urandom_range(1, 6)));
            write_reg(CFG_TRANSITION_FRAMES, 8'($urandom_range(0, 12)));
            phase_start = n_ticks;
            while (n_ticks - phase_start < 25) begin
                if ($urandom_range(0, 9) < 7) begin
                    run = $urandom_range(1, (det_frames > 8'd9) ? 12 : int'(det_frames) + 3);
                    repeat (run) send_above;
                    run = $urandom_range(1, 3 * (int'(trans_frames) + 1) + 2);
                    repeat (run) send_below;
                end else begin
                    repeat ($urandom_range(1, 6)) send_noise;
                end
            end
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure;
        drain;
        write_reg(CFG_DETECT_FRAMES, 8'd2);
        write_reg(CFG_TRANSITION_FRAMES, 8'd3);
        src_idle_en    = 1'b0;
        rx_hold_cycles = 150;
        repeat (16) send_noise;
        drain;                             // sender waits for every result
        src_idle_en = 1'b1;
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back;
        drain;
        write_reg(CFG_DETECT_FRAMES, 8'd1);
        write_reg(CFG_TRANSITION_FRAMES, 8'd1);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (6) begin
            repeat ($urandom_range(1, 4)) send_above;
            repeat ($urandom_range(1, 6)) send_below;
        end
        repeat (10) send_noise;
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_zero_frames();
        test_counter_bounds();
        test_random_sequences();
        test_backpressure();
        test_back_to_back();
        drain();

        $display("covered %0d ticks, %0d results, %0d train flags, %0d input stall cycles",
                 n_ticks, n_results, n_flags, n_in_stalls);
        $display("aspects seen: go %0d slow %0d warn %0d stop %0d, %0d register writes",
                 aspect_seen[ASPECT_GO], aspect_seen[ASPECT_SLOW],
                 aspect_seen[ASPECT_WARN], aspect_seen[ASPECT_STOP], n_settings);
        if (err_count == 0 && expected_lamps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still owed", expected_lamps.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
